/* hw/rtl/otpt_pkg.sv */
// Shared types and codes for the one-shot and periodic timer table.
package otpt_pkg;

  localparam int ID_W   = 31;
  localparam int TIME_W = 32;

  // Operation codes carried on the input beat
  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Result kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NONE_DUE  = 2'd3;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              kind;
    logic [TIME_W-1:0] fire;
    logic [TIME_W-1:0] period;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;        // capture input beat
    logic add_exec;   // perform add and load reply
    logic scan_first; // start walk, read entry 0
    logic scan_exec;  // evaluate current entry
    logic fin_exec;   // load closing result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;    // table holds no entry
    logic more;     // another entry follows the current one
    logic stall;    // current entry must wait for the output register
    logic out_free; // output register can take a beat
  } stat_t;

endpackage

/* hw/rtl/one_shot_periodic_timer_table.sv */
// Top level of the one-shot and periodic timer table.
//
// Input channel (in_valid/in_ready) carries one request beat: add a job,
// remove a job by id, or a time tick. Output channel (out_valid/out_ready)
// carries result beats; last marks the final beat caused by a request.
// An add moves to a reply state that waits until the output register is
// free, then loads its one beat there and frees the input with that load.
// Remove and tick walk the table one entry per cycle from a registered-read
// RAM, unless a stall holds the walk; a tick gives one beat per due job in
// table order, or a single nothing-due beat when none is due. Entries are
// compacted in the same pass. A new request is taken only once the previous
// one has loaded its last beat into the output register; that register lets
// the next request start while the last beat still waits. When the receiver
// stalls, the walk pauses on the next due job until the output frees.
// Reset empties the table and restarts ids at 1; RAM contents need no
// clearing, as only entries below the count are read.
module one_shot_periodic_timer_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic                        job_kind,
  input  logic [otpt_pkg::TIME_W-1:0] time_value,
  input  logic [otpt_pkg::ID_W-1:0]   job_number,
  input  logic [otpt_pkg::TIME_W-1:0] now_seconds,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  result_kind,
  output logic [1:0]                  status,
  output logic [otpt_pkg::ID_W-1:0]   job_number_out,
  output logic                        last
);
  import otpt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  otpt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func    (func),
    .stat    (stat),
    .cmd     (cmd)
  );

  otpt_dp #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .func          (func),
    .job_kind      (job_kind),
    .time_value    (time_value),
    .job_number    (job_number),
    .now_seconds   (now_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .status        (status),
    .job_number_out(job_number_out),
    .last          (last)
  );

`ifndef SYNTHESIS
  // An accepted add keeps the block busy in its reply state
  a_add_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_ADD |=> !in_ready)
    else $error("add accepted without a busy cycle");

  // Only tick reports come in groups
  a_nonlast_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> result_kind == KIND_TICK)
    else $error("non-final beat on a single-result request");

  // Nothing-due report stands alone and carries no id
  a_none_due: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NONE_DUE |-> last && job_number_out == '0)
    else $error("malformed nothing-due beat");

  // A non-final beat means the walk is still running
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("request taken before its last beat was loaded");
`endif

endmodule

/* hw/rtl/otpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module otpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/otpt_ctrl.sv */
// Sequencing state machine for the timer table.
module otpt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     func,
  input  otpt_pkg::stat_t stat,
  output otpt_pkg::cmd_t  cmd
);
  import otpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          case (func)
            FUNC_ADD: begin
              state_next = S_ADD;
            end
            FUNC_REMOVE, FUNC_TICK: begin
              cmd.scan_first = 1'b1;
              state_next     = stat.empty ? S_FIN : S_SCAN;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_ADD: begin
        if (stat.out_free) begin
          cmd.add_exec = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!stat.stall) begin
          cmd.scan_exec = 1'b1;
          if (!stat.more) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin_exec = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/otpt_dp.sv */
// Datapath: entry RAM, counters, table walk with compaction, result register.
module otpt_dp #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  otpt_pkg::cmd_t                cmd,
  output otpt_pkg::stat_t               stat,
  input  logic [1:0]                    func,
  input  logic                          job_kind,
  input  logic [otpt_pkg::TIME_W-1:0]   time_value,
  input  logic [otpt_pkg::ID_W-1:0]     job_number,
  input  logic [otpt_pkg::TIME_W-1:0]   now_seconds,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    result_kind,
  output logic [1:0]                    status,
  output logic [otpt_pkg::ID_W-1:0]     job_number_out,
  output logic                          last
);
  import otpt_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = $clog2(MAX_ENTRIES > 1 ? MAX_ENTRIES : 2);

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  // Captured input beat
  logic [1:0]        op_func;
  logic              op_kind;
  logic [TIME_W-1:0] op_tval;
  logic [ID_W-1:0]   op_number;
  logic [TIME_W-1:0] op_now;

  // Table bookkeeping
  logic [CNT_W-1:0] count;
  logic [ID_W-1:0]  next_num;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] keep;
  logic             found;
  logic             pend_valid;
  logic [ID_W-1:0]  pend_id;

  // RAM port signals
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  entry_t            wr_data, rd_data;

  // Walk decode
  logic [CNT_W-1:0]  idx_inc, keep_next;
  logic              is_tick, match, due, drop, fired, full, out_free;
  logic [TIME_W-1:0] add_b, sum;
  entry_t            new_entry, upd_entry;
  logic [ID_W-1:0]   nn_inc;

  // Output load
  logic        out_load;
  logic [1:0]  ld_kind, ld_status;
  logic [ID_W-1:0] ld_id;
  logic        ld_last;

  otpt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Entry evaluation
  always_comb begin
    idx_inc   = idx + 1'b1;
    is_tick   = (op_func == FUNC_TICK);
    match     = !found && (rd_data.id == op_number);
    due       = (op_now >= rd_data.fire);
    fired     = is_tick && due;
    drop      = is_tick ? (due && !rd_data.kind) : match;
    keep_next = drop ? keep : keep + 1'b1;
    add_b     = (op_func == FUNC_ADD) ? op_tval : rd_data.period;
    sum       = sat_add(op_now, add_b);
    full      = (count >= CNT_W'(MAX_ENTRIES));
    out_free  = !out_valid || out_ready;
    nn_inc    = next_num + 1'b1;

    new_entry.id     = next_num;
    new_entry.kind   = op_kind;
    new_entry.fire   = op_kind ? sum : op_tval;
    new_entry.period = op_kind ? op_tval : '0;

    upd_entry      = rd_data;
    upd_entry.fire = (fired && rd_data.kind) ? sum : rd_data.fire;

    stat.empty    = (count == '0);
    stat.more     = (idx_inc < count);
    stat.stall    = fired && pend_valid && !out_free;
    stat.out_free = out_free;
  end

  // RAM access: appends on add, compacting write-back during the walk
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    wr_data = new_entry;
    if (cmd.add_exec && !full) begin
      wr_en = 1'b1;
    end else if (cmd.scan_exec && !drop) begin
      wr_en   = 1'b1;
      wr_addr = keep[ADDR_W-1:0];
      wr_data = upd_entry;
    end
    rd_en   = cmd.scan_first || (cmd.scan_exec && stat.more);
    rd_addr = cmd.scan_first ? '0 : idx_inc[ADDR_W-1:0];
  end

  // Result selection
  always_comb begin
    out_load  = 1'b0;
    ld_kind   = KIND_TICK;
    ld_status = ST_OK;
    ld_id     = pend_id;
    ld_last   = 1'b1;
    if (cmd.add_exec) begin
      out_load  = 1'b1;
      ld_kind   = KIND_ADD;
      ld_status = full ? ST_FULL : ST_OK;
      ld_id     = full ? '0 : next_num;
    end else if (cmd.scan_exec && fired && pend_valid) begin
      out_load = 1'b1;
      ld_last  = 1'b0;
    end else if (cmd.fin_exec) begin
      out_load = 1'b1;
      if (op_func == FUNC_REMOVE) begin
        ld_kind   = KIND_REMOVE;
        ld_status = found ? ST_OK : ST_NOT_FOUND;
        ld_id     = found ? op_number : '0;
      end else if (!pend_valid) begin
        ld_status = ST_NONE_DUE;
        ld_id     = '0;
      end
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_func   <= func;
      op_kind   <= job_kind;
      op_tval   <= time_value;
      op_number <= job_number;
      op_now    <= now_seconds;
    end
  end

  // Counters and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      next_num   <= ID_W'(1);
      idx        <= '0;
      keep       <= '0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.add_exec && !full) begin
        count    <= count + 1'b1;
        next_num <= (nn_inc == '0) ? ID_W'(1) : nn_inc;
      end
      if (cmd.scan_first) begin
        idx        <= '0;
        keep       <= '0;
        found      <= 1'b0;
        pend_valid <= 1'b0;
      end else if (cmd.scan_exec) begin
        idx  <= idx_inc;
        keep <= keep_next;
        if (!is_tick && match) begin
          found <= 1'b1;
        end
        if (fired) begin
          pend_valid <= 1'b1;
        end
        if (!stat.more) begin
          count <= keep_next;
        end
      end
    end
  end

  // Pending fired id, sent once the next fired id or the end is known
  always_ff @(posedge clk) begin
    if (cmd.scan_exec && fired) begin
      pend_id <= rd_data.id;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind    <= ld_kind;
      status         <= ld_status;
      job_number_out <= ld_id;
      last           <= ld_last;
    end
  end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the timer table: random and directed jobs, scoreboard in a class.
`timescale 1ns / 1ps

module testbench;
  import otpt_pkg::*;

  // One result beat as seen on the output channel
  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      status;
    logic [ID_W-1:0] id;
    logic            last;
  } reply_t;

  // Shadow copy of the job table plus the queue of replies still owed
  class timer_table_sb #(int DEPTH = 16);
    logic [ID_W-1:0]   job_ids   [DEPTH];
    logic              job_kinds [DEPTH];
    logic [TIME_W-1:0] fire_at   [DEPTH];
    logic [TIME_W-1:0] periods   [DEPTH];
    int                job_count;
    logic [ID_W-1:0]   next_id;
    reply_t            queued_replies[$];
    int                mismatches;

    function new();
      job_count  = 0;
      next_id    = 1;
      mismatches = 0;
    endfunction

    function logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    function void push_reply(logic [1:0] kind, logic [1:0] st, logic [ID_W-1:0] id,
                             logic lst);
      reply_t r;
      r.kind   = kind;
      r.status = st;
      r.id     = id;
      r.last   = lst;
      queued_replies.push_back(r);
    endfunction

    function void move_job(int dst, int src);
      job_ids[dst]   = job_ids[src];
      job_kinds[dst] = job_kinds[src];
      fire_at[dst]   = fire_at[src];
      periods[dst]   = periods[src];
    endfunction

    // Update the table for one accepted request and queue its replies
    function void note_request(func_t op, logic kind, logic [TIME_W-1:0] tval,
                               logic [ID_W-1:0] number, logic [TIME_W-1:0] now);
      int  hit;
      int  keep;
      int  fired;
      bit  drop;
      case (op)
        FUNC_ADD: begin
          if (job_count >= DEPTH) begin
            push_reply(KIND_ADD, ST_FULL, '0, 1'b1);
          end else begin
            job_ids[job_count]   = next_id;
            job_kinds[job_count] = kind;
            fire_at[job_count]   = kind ? sat_sum(now, tval) : tval;
            periods[job_count]   = kind ? tval : '0;
            job_count++;
            push_reply(KIND_ADD, ST_OK, next_id, 1'b1);
            // ids wrap past the top and skip zero
            next_id = next_id + 1'b1;
            if (next_id == '0) next_id = 1;
          end
        end
        FUNC_REMOVE: begin
          hit = -1;
          for (int i = 0; i < job_count; i++)
            if (hit < 0 && job_ids[i] == number) hit = i;
          if (hit < 0) begin
            push_reply(KIND_REMOVE, ST_NOT_FOUND, '0, 1'b1);
          end else begin
            for (int k = hit; k + 1 < job_count; k++) move_job(k, k + 1);
            job_count--;
            push_reply(KIND_REMOVE, ST_OK, number, 1'b1);
          end
        end
        FUNC_TICK: begin
          keep  = 0;
          fired = 0;
          // fire due jobs in order, drop one-shots, compact in the same pass
          for (int i = 0; i < job_count; i++) begin
            drop = 1'b0;
            if (now >= fire_at[i]) begin
              push_reply(KIND_TICK, ST_OK, job_ids[i], 1'b0);
              fired++;
              if (job_kinds[i]) fire_at[i] = sat_sum(now, periods[i]);
              else drop = 1'b1;
            end
            if (!drop) begin
              move_job(keep, i);
              keep++;
            end
          end
          job_count = keep;
          if (fired == 0) push_reply(KIND_TICK, ST_NONE_DUE, '0, 1'b1);
          else queued_replies[queued_replies.size()-1].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat with the oldest owed reply
    function void check_reply(reply_t got);
      reply_t want;
      if (queued_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d status %0d id %0d last %0b",
                   got.kind, got.status, got.id, got.last);
        return;
      end
      want = queued_replies.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected kind %0d status %0d id %0d last %0b,",
                   want.kind, want.status, want.id, want.last,
                   " got kind %0d status %0d id %0d last %0b",
                   got.kind, got.status, got.id, got.last);
      end
    endfunction

    function int outstanding();
      return queued_replies.size();
    endfunction

    // Id of a job now in the table, or a random id when the table is empty
    function logic [ID_W-1:0] live_id();
      if (job_count == 0) return ID_W'($urandom);
      return job_ids[$urandom_range(job_count - 1)];
    endfunction
  endclass

  localparam int TABLE_DEPTH  = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        func;
  logic              job_kind;
  logic [TIME_W-1:0] time_value;
  logic [ID_W-1:0]   job_number;
  logic [TIME_W-1:0] now_seconds;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        result_kind;
  logic [1:0]        status;
  logic [ID_W-1:0]   job_number_out;
  logic              last;

  timer_table_sb #(TABLE_DEPTH) sb;

  int                send_idle   = 17;
  int                recv_idle   = 51;
  bit                hold_req    = 1'b0;
  int                quiet_cycles = 0;
  logic [TIME_W-1:0] wall_clock  = 32'd1000;

  one_shot_periodic_timer_table #(.MAX_ENTRIES(TABLE_DEPTH)) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .job_kind       (job_kind),
    .time_value     (time_value),
    .job_number     (job_number),
    .now_seconds    (now_seconds),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .status         (status),
    .job_number_out (job_number_out),
    .last           (last)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one request beat, hold it until taken, then record it
  task automatic send_request(input func_t op, input logic kind,
                              input logic [TIME_W-1:0] tval,
                              input logic [ID_W-1:0] number,
                              input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= op;
    job_kind    <= kind;
    time_value  <= tval;
    job_number  <= number;
    now_seconds <= now;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, kind, tval, number, now);
  endtask

  // Mostly well-formed traffic around a slowly advancing wall clock
  task automatic random_batch(input int count);
    int                done;
    int                roll;
    int                add_share;
    func_t             op;
    logic              kind;
    logic [TIME_W-1:0] tval;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   number;
    done = 0;
    while (done < count) begin
      roll   = $urandom_range(99);
      kind   = 1'($urandom_range(1));
      tval   = $urandom;
      number = ID_W'($urandom);
      now    = wall_clock;
      // keep the table busy but let it hit full now and then
      if (sb.job_count < 4) add_share = 60;
      else if (sb.job_count >= TABLE_DEPTH) add_share = 20;
      else add_share = 40;
      if (roll < 4) begin
        op = FUNC_NONE;
      end else if (roll < 4 + add_share) begin
        op = FUNC_ADD;
        if ($urandom_range(9) != 0)
          tval = kind ? 32'($urandom_range(25)) : wall_clock + $urandom_range(40);
        if ($urandom_range(9) == 0) now = $urandom;
      end else if (roll < 4 + add_share + 25) begin
        op = FUNC_REMOVE;
        if ($urandom_range(4) != 0) number = sb.live_id();
      end else begin
        op = FUNC_TICK;
        wall_clock = wall_clock + $urandom_range(15);
        now = ($urandom_range(19) == 0) ? $urandom : wall_clock;
      end
      send_request(op, kind, tval, number, now);
      if (op != FUNC_NONE) done++;
    end
  endtask

  // Receiver: random ready, with one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Check output beats and track cycles with no beat on either side
  always @(posedge clk) begin
    reply_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.kind   = result_kind;
      seen.status = status;
      seen.id     = job_number_out;
      seen.last   = last;
      sb.check_reply(seen);
    end
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // Watchdog
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    func        <= FUNC_NONE;
    job_kind    <= 1'b0;
    time_value  <= '0;
    job_number  <= '0;
    now_seconds <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every operation, full table, mass firing
    send_request(FUNC_ADD, 1'b0, '0, '0, '0);          // one-shot due at time zero
    send_request(FUNC_ADD, 1'b1, '1, '1, '1);          // periodic, first fire saturates
    send_request(FUNC_TICK, 1'b0, '0, '0, '0);         // fires the one-shot only
    send_request(FUNC_TICK, 1'b1, '1, '1, '0);         // nothing due
    send_request(FUNC_REMOVE, 1'b0, '0, '1, '0);       // unknown id
    send_request(FUNC_REMOVE, 1'b1, '0, 31'd2, '1);    // removes the periodic job
    send_request(FUNC_NONE, 1'b1, '1, '1, '1);         // unused code, ignored
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_request(FUNC_ADD, i[0], i[0] ? 32'((i / 2) % 3) : 32'(i * 9), '0, 32'd100);
    send_request(FUNC_ADD, 1'b1, 32'd1, '0, 32'd100);  // refused, table full
    send_request(FUNC_TICK, 1'b0, '0, '0, 32'd100);    // some due, some not
    send_request(FUNC_TICK, 1'b0, '0, '0, '1);         // all due, periodics saturate

    // let everything drain before the random traffic
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);

    random_batch(44);
    send_idle = 51;
    recv_idle = 17;
    random_batch(44);
    // no idling; receiver backs off long enough to stall the input
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    random_batch(44);

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/otpt_pkg.sv
hw/rtl/otpt_ram.sv
hw/rtl/otpt_ctrl.sv
hw/rtl/otpt_dp.sv
hw/rtl/one_shot_periodic_timer_table.sv
test/testbench.sv
